// ===== rtl/fcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpt_pkg
// Shared types and constants of the four-channel PWM timer.
// ----------------------------------------------------------------------------
package fcpt_pkg;

  localparam int NumChannels = 4;
  localparam int CounterBits = 16;
  localparam int ChanBits    = 2;
  localparam int DutyBits    = 17;
  localparam int ClkBits     = 32;
  localparam int FreqBits    = 20;
  localparam int ResBits     = 17;
  localparam int DenBits     = 37;
  localparam int CfgIdxBits  = 2;

  localparam logic [DutyBits-1:0]    DutyOne = 17'h10000;
  localparam logic [CounterBits-1:0] CntMax  = 16'hFFFF;

  localparam logic [2:0] ActTick    = 3'd0;
  localparam logic [2:0] ActDuty    = 3'd1;
  localparam logic [2:0] ActEnable  = 3'd2;
  localparam logic [2:0] ActDisable = 3'd3;
  localparam logic [2:0] ActStart   = 3'd4;
  localparam logic [2:0] ActStop    = 3'd5;

  localparam logic [CfgIdxBits-1:0] CfgClk  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgFreq = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgRes  = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_DUTY,
    OP_ENABLE,
    OP_DISABLE,
    OP_START,
    OP_STOP,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [ChanBits-1:0] ch;
    logic [DutyBits-1:0] duty;
    logic                mode;
    logic                inv;
  } cmd_t;

endpackage

// ===== rtl/four_channel_pwm_timer.sv =====
// ----------------------------------------------------------------------------
// four_channel_pwm_timer
// Four-channel PWM timer with prescaler, auto-reload counter and compares.
// ----------------------------------------------------------------------------
// Every action yields one result beat. Tick, set duty, enable, disable, stop,
// unknown codes and a start while running are each done from the idle state,
// so a stream of ticks runs at one beat per cycle while results are taken.
// A start from the stopped state runs in the back end: one multiply, 32 steps
// of the shared restoring divider for the prescaler, one multiply and 32 more
// steps for the reload, then a commit state. The two-deep command queue takes
// up to two more beats meanwhile and then holds the input off until the start
// completes. Configuration registers take effect at the next start while stopped.
module four_channel_pwm_timer import fcpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [ClkBits-1:0]     cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             action_i,
  input  logic [ChanBits-1:0]    channel_i,
  input  logic [DutyBits-1:0]    duty_fraction_i,
  input  logic                   pwm_mode_i,
  input  logic                   active_low_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [NumChannels-1:0] pwm_levels_o,
  output logic [CounterBits-1:0] count_value_o,
  output logic                   period_wrap_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  fcpt_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .channel_i,
    .duty_fraction_i,
    .pwm_mode_i,
    .active_low_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  fcpt_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o,
    .out_ready_i,
    .pwm_levels_o,
    .count_value_o,
    .period_wrap_o
  );

endmodule

// ===== rtl/fcpt_front.sv =====
// ----------------------------------------------------------------------------
// fcpt_front
// Accepts input beats, decodes the action and queues commands (two deep).
// ----------------------------------------------------------------------------
module fcpt_front import fcpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          action_i,
  input  logic [ChanBits-1:0] channel_i,
  input  logic [DutyBits-1:0] duty_fraction_i,
  input  logic                pwm_mode_i,
  input  logic                active_low_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    unique case (action_i)
      ActTick:    dec.op = OP_TICK;
      ActDuty:    dec.op = OP_DUTY;
      ActEnable:  dec.op = OP_ENABLE;
      ActDisable: dec.op = OP_DISABLE;
      ActStart:   dec.op = OP_START;
      ActStop:    dec.op = OP_STOP;
      default:    dec.op = OP_NOP;
    endcase
    dec.ch   = channel_i;
    // saturate duty above one
    dec.duty = (duty_fraction_i > DutyOne) ? DutyOne : duty_fraction_i;
    dec.mode = pwm_mode_i;
    dec.inv  = active_low_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= dec;
  end

endmodule

// ===== rtl/fcpt_back.sv =====
// ----------------------------------------------------------------------------
// fcpt_back
// Executes queued commands, holds timer state and the result register.
// A start from the stopped state runs two restoring divisions on one shared divider.
// ----------------------------------------------------------------------------
module fcpt_back import fcpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [ClkBits-1:0]     cfg_data_i,
  input  logic                   cmd_valid_i,
  input  cmd_t                   cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [NumChannels-1:0] pwm_levels_o,
  output logic [CounterBits-1:0] count_value_o,
  output logic                   period_wrap_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_DIV1, ST_MUL2, ST_DIV2, ST_COMMIT
  } state_e;

  state_e state_q, state_d;

  logic [ClkBits-1:0]  clk_hz_q;
  logic [FreqBits-1:0] freq_q;
  logic [ResBits-1:0]  res_q;

  logic [CounterBits-1:0] psc_div_q, psc_div_d, reload_q, reload_d;
  logic [CounterBits-1:0] psc_cnt_q, psc_cnt_d, main_q, main_d;
  logic [CounterBits-1:0] cmp_act_q [NumChannels];
  logic [CounterBits-1:0] cmp_act_d [NumChannels];
  logic [CounterBits-1:0] cmp_pend_q [NumChannels];
  logic [CounterBits-1:0] cmp_pend_d [NumChannels];
  logic [NumChannels-1:0] en_q, en_d, mode_q, mode_d, inv_q, inv_d;
  logic                   run_q, run_d;

  logic [DenBits-1:0]     den_q, den_d;
  logic [DenBits:0]       rem_q, rem_d, rem_sh;
  logic [ClkBits-1:0]     dvd_q, dvd_d, q_nxt;
  logic [4:0]             it_q, it_d;
  logic [CounterBits-1:0] psc_tmp_q, psc_tmp_d, rel_tmp_q, rel_tmp_d;

  logic                   out_valid_q, out_valid_d, wrap_q, wrap_d;
  logic [NumChannels-1:0] lev_q, lev_d;
  logic [CounterBits-1:0] cnt_q, cnt_d;

  logic                   can_issue, fire, pop;
  logic [DutyBits+CounterBits-1:0] prod;
  logic [CounterBits-1:0] quo_sat;

  assign can_issue = !out_valid_q || out_ready_i;

  // one restoring division step
  always_comb begin
    rem_sh = {rem_q[DenBits-1:0], dvd_q[ClkBits-1]};
    if (rem_sh >= {1'b0, den_q}) begin
      rem_d = rem_sh - {1'b0, den_q};
      q_nxt = {dvd_q[ClkBits-2:0], 1'b1};
    end else begin
      rem_d = rem_sh;
      q_nxt = {dvd_q[ClkBits-2:0], 1'b0};
    end
    quo_sat = (q_nxt[ClkBits-1:CounterBits] != '0) ? CntMax : q_nxt[CounterBits-1:0];
  end

  assign prod = cmd_i.duty * reload_q;

  always_comb begin
    state_d    = state_q;
    psc_div_d  = psc_div_q;
    reload_d   = reload_q;
    psc_cnt_d  = psc_cnt_q;
    main_d     = main_q;
    cmp_act_d  = cmp_act_q;
    cmp_pend_d = cmp_pend_q;
    en_d       = en_q;
    mode_d     = mode_q;
    inv_d      = inv_q;
    run_d      = run_q;
    den_d      = den_q;
    dvd_d      = dvd_q;
    it_d       = it_q;
    psc_tmp_d  = psc_tmp_q;
    rel_tmp_d  = rel_tmp_q;
    wrap_d     = 1'b0;
    fire       = 1'b0;
    pop        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && can_issue) begin
          pop = 1'b1;
          case (cmd_i.op)
            OP_TICK: begin
              if (run_q) begin
                if (psc_cnt_q < psc_div_q) begin
                  psc_cnt_d = psc_cnt_q + 1'b1;
                end else begin
                  psc_cnt_d = '0;
                  if (main_q >= reload_q) begin
                    main_d    = '0;
                    cmp_act_d = cmp_pend_q;
                    wrap_d    = 1'b1;
                  end else begin
                    main_d = main_q + 1'b1;
                  end
                end
              end
            end
            OP_DUTY: cmp_pend_d[cmd_i.ch] = prod[DutyBits+CounterBits-2:CounterBits];
            OP_ENABLE: begin
              en_d[cmd_i.ch]       = 1'b1;
              mode_d[cmd_i.ch]     = cmd_i.mode;
              inv_d[cmd_i.ch]      = cmd_i.inv;
              cmp_pend_d[cmd_i.ch] = prod[DutyBits+CounterBits-2:CounterBits];
            end
            OP_DISABLE: en_d[cmd_i.ch] = 1'b0;
            OP_STOP:    run_d = 1'b0;
            default: ;
          endcase
          if (cmd_i.op == OP_START && !run_q) state_d = ST_MUL1;
          else fire = 1'b1;
        end
      end
      ST_MUL1: begin
        den_d   = DenBits'(res_q) * DenBits'(freq_q);
        dvd_d   = clk_hz_q;
        it_d    = '0;
        state_d = ST_DIV1;
      end
      ST_DIV1: begin
        dvd_d = q_nxt;
        it_d  = it_q + 1'b1;
        if (it_q == 5'd31) begin
          psc_tmp_d = quo_sat;
          state_d   = ST_MUL2;
        end
      end
      ST_MUL2: begin
        den_d   = DenBits'({1'b0, psc_tmp_q} + 17'd1) * DenBits'(freq_q);
        dvd_d   = clk_hz_q;
        it_d    = '0;
        state_d = ST_DIV2;
      end
      ST_DIV2: begin
        dvd_d = q_nxt;
        it_d  = it_q + 1'b1;
        if (it_q == 5'd31) begin
          rel_tmp_d = quo_sat;
          state_d   = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (can_issue) begin
          psc_div_d = psc_tmp_q;
          reload_d  = rel_tmp_q;
          psc_cnt_d = '0;
          main_d    = '0;
          cmp_act_d = cmp_pend_q;
          run_d     = 1'b1;
          fire      = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    for (int i = 0; i < NumChannels; i++) begin
      lev_d[i] = run_d && en_d[i] &&
                 ((mode_d[i] ? (main_d >= cmp_act_d[i]) : (main_d < cmp_act_d[i]))
                  != inv_d[i]);
    end
    cnt_d = main_d;
    out_valid_d = fire ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  assign cmd_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clk_hz_q    <= 32'd84000000;
      freq_q      <= 20'd50;
      res_q       <= 17'd1000;
      psc_div_q   <= '0;
      reload_q    <= '0;
      psc_cnt_q   <= '0;
      main_q      <= '0;
      cmp_act_q   <= '{default: '0};
      cmp_pend_q  <= '{default: '0};
      en_q        <= '0;
      mode_q      <= '0;
      inv_q       <= '0;
      run_q       <= 1'b0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      psc_div_q   <= psc_div_d;
      reload_q    <= reload_d;
      psc_cnt_q   <= psc_cnt_d;
      main_q      <= main_d;
      cmp_act_q   <= cmp_act_d;
      cmp_pend_q  <= cmp_pend_d;
      en_q        <= en_d;
      mode_q      <= mode_d;
      inv_q       <= inv_d;
      run_q       <= run_d;
      it_q        <= it_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgClk:  clk_hz_q <= cfg_data_i;
          CfgFreq: freq_q   <= cfg_data_i[FreqBits-1:0];
          CfgRes:  res_q    <= cfg_data_i[ResBits-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    den_q     <= den_d;
    rem_q     <= (state_q == ST_MUL1 || state_q == ST_MUL2) ? '0 : rem_d;
    dvd_q     <= dvd_d;
    psc_tmp_q <= psc_tmp_d;
    rel_tmp_q <= rel_tmp_d;
    if (fire) begin
      lev_q  <= lev_d;
      cnt_q  <= cnt_d;
      wrap_q <= wrap_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pwm_levels_o  = lev_q;
  assign count_value_o = cnt_q;
  assign period_wrap_o = wrap_q;

endmodule
